// File: sv/dspe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspe_pkg
// Shared types and constants of the dense shortest-path engine: command and
// result items, operation codes, and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package dspe_pkg;

  // fixed field widths of the item channels
  localparam int OP_W       = 2;
  localparam int VERTEX_W   = 5;
  localparam int EDGE_LEN_W = 16;
  localparam int PATH_W     = 21;

  // saturation value of the reported distance
  localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

  // at most this many vertices are reported by a run
  localparam int REPORT_CAP = 32;

  // command operation codes
  typedef enum logic [OP_W-1:0] {
    OP_SET_EDGE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_RUN      = 2'd2
  } op_e;

  // command item
  typedef struct packed {
    logic [OP_W-1:0]       operation;
    logic [VERTEX_W-1:0]   node_a;
    logic [VERTEX_W-1:0]   node_b;
    logic [EDGE_LEN_W-1:0] edge_length;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [PATH_W-1:0]   path_length;
    logic [VERTEX_W-1:0] previous_vertex;
    logic                reachable;
    logic                last;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic run_init;
    logic clr_step;
    logic edge_wr0;
    logic edge_wr1;
    logic round_start;
    logic scan_step;
    logic emit_start;
    logic emit_ld;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    op_e  in_op;
    logic in_edge_ok;
    logic clr_done;
    logic scan_done;
    logic found;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/dspe_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspe_stream_if
// Valid/ready item channel with a typed payload, used for commands and results.
// ----------------------------------------------------------------------------
interface dspe_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: sv/dspe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspe_ctrl
// Sequencer of the engine: clearing sweep, edge writes, search rounds of
// pick and scan, and the result emission.
// ----------------------------------------------------------------------------
module dspe_ctrl import dspe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_EDGE0   = 8'b0000_0100,
    ST_EDGE1   = 8'b0000_1000,
    ST_PICK    = 8'b0001_0000,
    ST_SCAN    = 8'b0010_0000,
    ST_EMIT_RD = 8'b0100_0000,
    ST_EMIT_LD = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    ctl        = '0;
    cmd_ready  = 1'b0;
    case (state)
      ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl.accept = 1'b1;
          case (sts.in_op)
            OP_SET_EDGE: begin
              if (sts.in_edge_ok) begin
                state_next = ST_EDGE0;
              end
            end
            OP_CLEAR: begin
              state_next = ST_CLEAR;
            end
            OP_RUN: begin
              ctl.run_init = 1'b1;
              state_next   = ST_PICK;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_EDGE0: begin
        ctl.edge_wr0 = 1'b1;
        state_next   = ST_EDGE1;
      end
      ST_EDGE1: begin
        ctl.edge_wr1 = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_PICK: begin
        if (sts.found) begin
          ctl.round_start = 1'b1;
          state_next      = ST_SCAN;
        end else begin
          ctl.emit_start = 1'b1;
          state_next     = ST_EMIT_RD;
        end
      end
      ST_SCAN: begin
        if (!sts.scan_done) begin
          ctl.scan_step = 1'b1;
        end else begin
          state_next = ST_PICK;
        end
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          ctl.emit_ld = 1'b1;
          state_next  = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/dspe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspe_datapath
// Adjacency matrix memory, distance and predecessor memories, reached and
// settled flags, the relax/minimum stage of a scan and the result register.
// ----------------------------------------------------------------------------
module dspe_datapath import dspe_pkg::*; #(
  parameter int VERTICES  = 32,
  parameter int EDGE_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd_data,
  input  ctl_t ctl,
  output sts_t sts,
  output logic res_valid,
  output res_t res_data,
  input  logic res_ready
);

  localparam int VIDX_W  = $clog2(VERTICES);
  localparam int VCNT_W  = $clog2(VERTICES + 1);
  localparam int VDEPTH  = 1 << VIDX_W;
  localparam int ADDR_W  = 2 * VIDX_W;
  localparam int MDEPTH  = 1 << ADDR_W;
  localparam int DIST_W  = EDGE_BITS + VIDX_W;
  localparam int ENTRY_W = EDGE_BITS + 1;
  localparam int REPORT  = (VERTICES < REPORT_CAP) ? VERTICES : REPORT_CAP;
  localparam int WIDE_W  = (DIST_W > PATH_W) ? DIST_W : PATH_W;

  // latched edge command
  logic [VIDX_W-1:0]    node_a;
  logic [VIDX_W-1:0]    node_b;
  logic [EDGE_BITS-1:0] weight;

  // adjacency matrix: present bit over weight
  logic [ENTRY_W-1:0] edge_mem [0:MDEPTH-1];
  logic [ENTRY_W-1:0] edge_rd;
  logic               edge_we;
  logic [ADDR_W-1:0]  edge_waddr;
  logic [ENTRY_W-1:0] edge_wdata;
  logic [ADDR_W-1:0]  clr_addr;

  // per-vertex search state
  logic [DIST_W-1:0]   dist_mem [0:VDEPTH-1];
  logic [VIDX_W-1:0]   pred_mem [0:VDEPTH-1];
  logic [DIST_W-1:0]   dist_rd;
  logic [VIDX_W-1:0]   pred_rd;
  logic                vert_we;
  logic [VIDX_W-1:0]   vert_waddr;
  logic [DIST_W-1:0]   dist_wdata;
  logic [VIDX_W-1:0]   pred_wdata;
  logic [VERTICES-1:0] reached;
  logic [VERTICES-1:0] settled;

  // scan control
  logic [VCNT_W-1:0] vcnt;
  logic [VIDX_W-1:0] vidx;
  logic              s1_valid;
  logic [VIDX_W-1:0] s1_v;
  logic [VIDX_W-1:0] pick;
  logic [DIST_W-1:0] pick_dist;
  logic              best_found;
  logic [VIDX_W-1:0] best_v;
  logic [DIST_W-1:0] best_d;

  // relax stage
  logic [DIST_W-1:0] cand;
  logic              upd;
  logic              elig;
  logic              take;
  logic [DIST_W-1:0] new_d;

  // result formatting
  logic [WIDE_W-1:0] dist_wide;
  logic [PATH_W-1:0] path_sat;

  assign vidx = vcnt[VIDX_W-1:0];

  // status toward the controller
  always_comb begin
    sts.in_op      = op_e'(cmd_data.operation);
    sts.in_edge_ok = (int'(cmd_data.node_a) < VERTICES) &&
                     (int'(cmd_data.node_b) < VERTICES);
    sts.clr_done   = &clr_addr;
    sts.scan_done  = (vcnt == VCNT_W'(VERTICES));
    sts.found      = best_found;
    sts.emit_last  = (vcnt == VCNT_W'(REPORT - 1));
    sts.out_free   = !res_valid || res_ready;
  end

  // command capture
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      node_a <= VIDX_W'(cmd_data.node_a);
      node_b <= VIDX_W'(cmd_data.node_b);
      weight <= EDGE_BITS'(cmd_data.edge_length);
    end
  end

  // matrix write port: clearing sweep or one direction of an edge
  always_comb begin
    edge_we    = ctl.clr_step || ctl.edge_wr0 || ctl.edge_wr1;
    edge_waddr = ctl.clr_step ? clr_addr :
                 ctl.edge_wr0 ? {node_a, node_b} : {node_b, node_a};
    edge_wdata = ctl.clr_step ? '0 : {1'b1, weight};
  end

  // matrix memory, row of the picked vertex read at the scan index
  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd <= edge_mem[{pick, vidx}];
  end

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clr_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // relax the scanned vertex and track the next minimum
  always_comb begin
    cand  = pick_dist + DIST_W'(edge_rd[EDGE_BITS-1:0]);
    upd   = s1_valid && edge_rd[EDGE_BITS] && !settled[s1_v] &&
            (!reached[s1_v] || (cand < dist_rd));
    new_d = upd ? cand : dist_rd;
    elig  = s1_valid && (reached[s1_v] || upd) && !settled[s1_v];
    take  = elig && (!best_found || (new_d < best_d));
  end

  // distance and predecessor write port: source init or relax update
  always_comb begin
    vert_we    = ctl.run_init || upd;
    vert_waddr = ctl.run_init ? '0 : s1_v;
    dist_wdata = ctl.run_init ? '0 : cand;
    pred_wdata = ctl.run_init ? '0 : pick;
  end

  // per-vertex memories
  always_ff @(posedge clk) begin
    if (vert_we) begin
      dist_mem[vert_waddr] <= dist_wdata;
      pred_mem[vert_waddr] <= pred_wdata;
    end
    dist_rd <= dist_mem[vidx];
    pred_rd <= pred_mem[vidx];
  end

  // scan pipeline valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= ctl.scan_step;
    end
  end

  // scan / emit index
  always_ff @(posedge clk) begin
    s1_v <= vidx;
    if (ctl.round_start || ctl.emit_start) begin
      vcnt <= '0;
    end else if (ctl.scan_step || ctl.emit_ld) begin
      vcnt <= vcnt + 1'b1;
    end
  end

  // search state: init, round start, relax and minimum tracking
  always_ff @(posedge clk) begin
    if (ctl.run_init) begin
      reached    <= VERTICES'(1);
      settled    <= '0;
      best_found <= 1'b1;
      best_v     <= '0;
      best_d     <= '0;
    end else if (ctl.round_start) begin
      pick             <= best_v;
      pick_dist        <= best_d;
      settled[best_v]  <= 1'b1;
      best_found       <= 1'b0;
    end else begin
      if (upd) begin
        reached[s1_v] <= 1'b1;
      end
      if (take) begin
        best_found <= 1'b1;
        best_v     <= s1_v;
        best_d     <= new_d;
      end
    end
  end

  // saturate the distance to the result field
  always_comb begin
    dist_wide = WIDE_W'(dist_rd);
    path_sat  = (dist_wide > WIDE_W'(PATH_MAX)) ? PATH_MAX : PATH_W'(dist_wide);
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.emit_ld) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_ld) begin
      res_data.vertex          <= VERTEX_W'(vcnt);
      res_data.path_length     <= reached[vidx] ? path_sat : '0;
      res_data.previous_vertex <= reached[vidx] ? VERTEX_W'(pred_rd) : '0;
      res_data.reachable       <= reached[vidx];
      res_data.last            <= (vcnt == VCNT_W'(REPORT - 1));
    end
  end

endmodule

// File: sv/dense_shortest_path_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_shortest_path_engine_top
// Dense Dijkstra engine over an adjacency-matrix store, source vertex 0.
// ----------------------------------------------------------------------------
// Commands arrive on cmd: set an undirected edge, clear all edges, or run a
// search from vertex 0 that returns one item per vertex (up to 32) on res,
// the final one flagged with last. After reset, and after each clear command,
// the matrix memory (2**(2*ceil(log2 VERTICES)) entries, 1024 at 32 vertices)
// is swept one entry per cycle, during which cmd is not ready. An edge command
// is accepted and then written once per direction through the single write
// port of the matrix. A run settles one vertex per round; each round is a
// pick state plus a scan of the picked row at one matrix entry per cycle,
// for up to VERTICES rounds and a closing pick that finds nothing, followed
// by one read state and one load state per result, the load waiting while
// res is stalled. The last result may still wait in the output register
// while the next command is taken.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine_top import dspe_pkg::*; #(
  parameter int VERTICES  = 32,
  parameter int EDGE_BITS = 16
) (
  input logic            clk,
  input logic            rst,
  dspe_stream_if.sink    cmd,
  dspe_stream_if.source  res
);

  ctl_t ctl;
  sts_t sts;
  logic cmd_ready;
  logic res_valid;
  res_t res_data;

  assign cmd.ready = cmd_ready;
  assign res.valid = res_valid;
  assign res.data  = res_data;

  // sequencer
  dspe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  // storage and arithmetic
  dspe_datapath #(
    .VERTICES  (VERTICES),
    .EDGE_BITS (EDGE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd_data  (cmd.data),
    .ctl       (ctl),
    .sts       (sts),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_ready (res.ready)
  );

endmodule

// File: bench/dspe_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dspe_result_checker
// Watches the command and result channels of the shortest-path engine.
// Accepted commands update a private copy of the adjacency matrix; each run
// command computes the expected per-vertex distances, predecessors and
// reachable flags, which are queued and compared field by field against the
// result items as they are accepted. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module dspe_result_checker import dspe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  logic cmd_ready,
  input  cmd_t cmd_data,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res_data,
  output int   fail_count,
  output int   pending
);

  localparam int NODES = 32;

  // private copy of the adjacency matrix
  bit                    edge_on  [NODES][NODES];
  logic [EDGE_LEN_W-1:0] edge_len [NODES][NODES];

  // per-vertex results still owed by the engine, oldest first
  res_t expected_paths [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic clear_matrix();
    int a;
    int b;
    for (a = 0; a < NODES; a++) begin
      for (b = 0; b < NODES; b++) begin
        edge_on[a][b]  = 1'b0;
        edge_len[a][b] = '0;
      end
    end
  endtask

  // dijkstra from vertex 0, lowest index wins ties, equal relaxation keeps old
  task automatic predict_paths();
    logic [31:0]         path_dist [NODES];
    bit                  seen [NODES];
    bit                  done [NODES];
    logic [VERTEX_W-1:0] prev [NODES];
    logic [31:0]         pick_dist;
    logic [31:0]         cand;
    int                  pick;
    int                  v;
    int                  rnd;
    bit                  found;
    res_t                r;
    for (v = 0; v < NODES; v++) begin
      path_dist[v] = '0;
      seen[v] = 1'b0;
      done[v] = 1'b0;
      prev[v] = '0;
    end
    seen[0] = 1'b1;
    for (rnd = 0; rnd < NODES; rnd++) begin
      found = 1'b0;
      pick = 0;
      pick_dist = '0;
      for (v = 0; v < NODES; v++) begin
        if (seen[v] && !done[v] && (!found || path_dist[v] < pick_dist)) begin
          found = 1'b1;
          pick = v;
          pick_dist = path_dist[v];
        end
      end
      if (!found) break;
      done[pick] = 1'b1;
      for (v = 0; v < NODES; v++) begin
        if (edge_on[pick][v] && !done[v]) begin
          cand = pick_dist + edge_len[pick][v];
          if (!seen[v] || cand < path_dist[v]) begin
            seen[v] = 1'b1;
            path_dist[v] = cand;
            prev[v] = VERTEX_W'(pick);
          end
        end
      end
    end
    // one item per vertex, unreachable ones report zeros
    for (v = 0; v < NODES; v++) begin
      r.vertex = VERTEX_W'(v);
      r.reachable = seen[v];
      r.path_length = !seen[v] ? '0 :
                      (path_dist[v] > 32'(PATH_MAX)) ? PATH_MAX : PATH_W'(path_dist[v]);
      r.previous_vertex = seen[v] ? prev[v] : '0;
      r.last = (v == NODES - 1);
      expected_paths = {expected_paths, r};
    end
  endtask

  task automatic check_path(input res_t got);
    res_t want;
    if (expected_paths.size() == 0) begin
      report_mismatch($sformatf("unexpected result item for vertex %0d", got.vertex));
    end else begin
      want = expected_paths.pop_front();
      if (got.vertex !== want.vertex)
        report_mismatch($sformatf("vertex got %0d expected %0d", got.vertex, want.vertex));
      if (got.path_length !== want.path_length)
        report_mismatch($sformatf("vertex %0d path_length got %0d expected %0d",
                                  want.vertex, got.path_length, want.path_length));
      if (got.previous_vertex !== want.previous_vertex)
        report_mismatch($sformatf("vertex %0d previous_vertex got %0d expected %0d",
                                  want.vertex, got.previous_vertex, want.previous_vertex));
      if (got.reachable !== want.reachable)
        report_mismatch($sformatf("vertex %0d reachable got %0b expected %0b",
                                  want.vertex, got.reachable, want.reachable));
      if (got.last !== want.last)
        report_mismatch($sformatf("vertex %0d last got %0b expected %0b",
                                  want.vertex, got.last, want.last));
    end
  endtask

  // sample both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      clear_matrix();
      expected_paths.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (res_valid && res_ready) check_path(res_data);
      if (cmd_valid && cmd_ready) begin
        case (cmd_data.operation)
          OP_SET_EDGE: begin
            edge_on[cmd_data.node_a][cmd_data.node_b]  = 1'b1;
            edge_on[cmd_data.node_b][cmd_data.node_a]  = 1'b1;
            edge_len[cmd_data.node_a][cmd_data.node_b] = cmd_data.edge_length;
            edge_len[cmd_data.node_b][cmd_data.node_a] = cmd_data.edge_length;
          end
          OP_CLEAR: clear_matrix();
          OP_RUN:   predict_paths();
          default: ;
        endcase
      end
      pending <= expected_paths.size();
    end
  end

endmodule

// File: bench/dense_shortest_path_engine_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_shortest_path_engine_top_test
// Drives edge, clear and run commands into the shortest-path engine: a short
// directed graph set first, then random graphs followed by runs, under four
// idling phases on the command and result sides. The checker beside the
// engine predicts and compares every result item; the verdict is given here.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine_top_test;
  import dspe_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASE_ITEMS  = 20;

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   cycle_count;
  int   cmds_sent;
  int   fail_count;
  int   pending;

  dspe_stream_if #(.payload_t(cmd_t)) cmd_ch ();
  dspe_stream_if #(.payload_t(res_t)) res_ch ();

  dense_shortest_path_engine_top u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  dspe_result_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_ch.valid),
    .cmd_ready  (cmd_ch.ready),
    .cmd_data   (cmd_ch.data),
    .res_valid  (res_ch.valid),
    .res_ready  (res_ch.ready),
    .res_data   (res_ch.data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // result side back-pressure
  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // present one command and hold it until accepted, then maybe go idle
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VERTEX_W-1:0] a,
                          input logic [VERTEX_W-1:0] b,
                          input logic [EDGE_LEN_W-1:0] len);
    cmd_t c;
    int   gap;
    c.operation   = op;
    c.node_a      = a;
    c.node_b      = b;
    c.edge_length = len;
    cmd_ch.data  <= c;
    cmd_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (op != OP_UNUSED) cmds_sent++;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [EDGE_LEN_W-1:0] pick_length();
    case ($urandom_range(7))
      0, 1, 2: pick_length = EDGE_LEN_W'($urandom_range(15));
      3:       pick_length = '0;
      4:       pick_length = '1;
      default: pick_length = EDGE_LEN_W'($urandom);
    endcase
  endfunction

  // random graph on the low vertices, sometimes after a clear, then a run
  task automatic graph_then_run();
    int n;
    int k;
    int i;
    n = $urandom_range(2, 32);
    k = $urandom_range(1, 12);
    if ($urandom_range(3) == 0) send_cmd(OP_CLEAR, '0, '0, '0);
    for (i = 0; i < k; i++)
      send_cmd(OP_SET_EDGE, VERTEX_W'($urandom_range(n - 1)),
               VERTEX_W'($urandom_range(n - 1)), pick_length());
    send_cmd(OP_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom), EDGE_LEN_W'($urandom));
  endtask

  // stray items: unused code, lone edge, lone run, clear
  task automatic noise_item();
    case ($urandom_range(3))
      0: send_cmd(OP_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom),
                  EDGE_LEN_W'($urandom));
      1: send_cmd(OP_SET_EDGE, VERTEX_W'($urandom), VERTEX_W'($urandom), pick_length());
      2: send_cmd(OP_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom),
                  EDGE_LEN_W'($urandom));
      default: send_cmd(OP_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom),
                        EDGE_LEN_W'($urandom));
    endcase
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    int goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = cmds_sent + PHASE_ITEMS;
    while (cmds_sent < goal) begin
      if ($urandom_range(9) < 8) graph_then_run();
      else noise_item();
    end
  endtask

  initial begin
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cmds_sent      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty graph, extremes, ties, self loop, island, rewrite, clear
    send_cmd(OP_RUN, '0, '0, '0);
    send_cmd(OP_SET_EDGE, 5'd0, 5'd1, 16'hFFFF);
    send_cmd(OP_SET_EDGE, 5'd1, 5'd2, 16'h0000);
    send_cmd(OP_SET_EDGE, 5'd0, 5'd3, 16'd5);
    send_cmd(OP_SET_EDGE, 5'd0, 5'd5, 16'd5);
    send_cmd(OP_SET_EDGE, 5'd0, 5'd4, 16'd10);
    send_cmd(OP_SET_EDGE, 5'd3, 5'd4, 16'd5);
    send_cmd(OP_SET_EDGE, 5'd5, 5'd4, 16'd5);
    send_cmd(OP_SET_EDGE, 5'd2, 5'd2, 16'd7);
    send_cmd(OP_SET_EDGE, 5'd31, 5'd30, 16'd100);
    send_cmd(OP_UNUSED, 5'd31, 5'd31, 16'hFFFF);
    send_cmd(OP_RUN, 5'd31, 5'd31, 16'hFFFF);
    send_cmd(OP_SET_EDGE, 5'd1, 5'd0, 16'd1);
    send_cmd(OP_RUN, '0, '0, '0);
    send_cmd(OP_SET_EDGE, 5'd31, 5'd0, 16'hFFFF);
    send_cmd(OP_SET_EDGE, 5'd2, 5'd30, 16'hAAAA);
    send_cmd(OP_RUN, '0, '0, '0);
    send_cmd(OP_CLEAR, '0, '0, '0);
    send_cmd(OP_RUN, '0, '0, '0);

    // random graphs under each idling mix
    random_phase(0, 0);
    random_phase(84, 0);
    random_phase(0, 84);
    random_phase(16, 16);
    cmd_ch.valid <= 1'b0;

    // drain outstanding result items, once the last accept has been counted
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/dspe_pkg.sv
sv/dspe_stream_if.sv
sv/dspe_ctrl.sv
sv/dspe_datapath.sv
sv/dense_shortest_path_engine_top.sv
bench/dspe_result_checker.sv
bench/dense_shortest_path_engine_top_test.sv
